[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/dpem_pkg.sv]
// Types and constants of the dual pressure averager and health monitor.
package dpem_pkg;

	localparam int PRESS_W   = 16;
	localparam int VOLT_W    = 13;
	localparam int ALPHA_W   = 17;
	localparam int LIMIT_W   = 8;
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = ALPHA_W;

	// Q1.16 unity and the Q0.16 rounding half.
	localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;
	localparam logic [FRAC_BITS-1:0] HALF_Q16 = 16'h8000;

	// Register reset values.
	localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd6554;
	localparam logic               ENABLE_RST  = 1'b1;
	localparam logic [VOLT_W-1:0]  MIN_V_RST   = 13'd100;
	localparam logic [VOLT_W-1:0]  MAX_V_RST   = 13'd5000;
	localparam logic [LIMIT_W-1:0] LIMIT_RST   = 8'd5;

	// Register indexes on the write port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_ALPHA   = 3'd0,
		CFG_FILTER_ENABLE  = 3'd1,
		CFG_MIN_VOLTAGE_MV = 3'd2,
		CFG_MAX_VOLTAGE_MV = 3'd3,
		CFG_ERROR_LIMIT    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] filter_alpha;
		logic               filter_enable;
		logic [VOLT_W-1:0]  min_voltage_mv;
		logic [VOLT_W-1:0]  max_voltage_mv;
		logic [LIMIT_W-1:0] error_limit;
	} cfg_t;

	typedef struct packed {
		logic [PRESS_W-1:0] avl_pressure;
		logic               avl_pressure_ok;
		logic [VOLT_W-1:0]  avl_voltage;
		logic               avl_voltage_ok;
		logic [PRESS_W-1:0] tank_pressure;
		logic               tank_pressure_ok;
		logic [VOLT_W-1:0]  tank_voltage;
		logic               tank_voltage_ok;
	} in_item_t;

	typedef struct packed {
		logic [PRESS_W-1:0] avl_filtered;
		logic [PRESS_W-1:0] tank_filtered;
		logic               readings_valid;
		logic               avl_healthy;
		logic               tank_healthy;
		logic               avl_fault_event;
		logic               avl_recover_event;
		logic               tank_fault_event;
		logic               tank_recover_event;
	} out_item_t;

	// What one channel returns for one item.
	typedef struct packed {
		logic [PRESS_W-1:0] filtered;
		logic               healthy;
		logic               fault_event;
		logic               recover_event;
	} chan_res_t;

endpackage

[rtl/core/dpem_if.sv]
// Valid/ready channels that carry input items and result items.
interface dpem_in_if;
	logic               valid;
	logic               ready;
	dpem_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dpem_out_if;
	logic                valid;
	logic                ready;
	dpem_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/dpem_chan.sv]
// One channel: moving average of the pressure and voltage health counter.
module dpem_chan #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd,
	input  dpem_pkg::cfg_t                 cfg,
	input  logic [dpem_pkg::PRESS_W-1:0]   pressure,
	input  logic                           pressure_ok,
	input  logic [dpem_pkg::VOLT_W-1:0]    voltage,
	input  logic                           voltage_ok,
	output dpem_pkg::chan_res_t            res
);

	localparam int AVG_W  = SAMPLE_BITS + dpem_pkg::FRAC_BITS;
	localparam int NEW_W  = SAMPLE_BITS + dpem_pkg::ALPHA_W;
	localparam int PROD_W = AVG_W + dpem_pkg::ALPHA_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int CMP_W  = (COUNT_BITS > dpem_pkg::LIMIT_W) ? COUNT_BITS : dpem_pkg::LIMIT_W;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

	logic [AVG_W-1:0]                   avg_q;
	logic                               seeded_q;
	logic [COUNT_BITS-1:0]              cnt_q;
	logic                               health_q;

	logic [SAMPLE_BITS-1:0]             smp;
	logic [SAMPLE_BITS-1:0]             r_sat;
	logic [AVG_W-1:0]                   x;
	logic [dpem_pkg::ALPHA_W-1:0]       alpha_c;
	logic [dpem_pkg::ALPHA_W-1:0]       beta;
	logic [NEW_W-1:0]                   prod_new;
	logic [PROD_W-1:0]                  prod_old;
	logic [SUM_W-1:0]                   sum;
	logic [AVG_W-1:0]                   avg_next;
	logic [AVG_W:0]                     rnd;
	logic [SAMPLE_BITS:0]               r_full;
	logic                               fail;
	logic [COUNT_BITS-1:0]              cnt_up;
	logic [COUNT_BITS-1:0]              cnt_dn;
	logic [COUNT_BITS-1:0]              cnt_next;
	logic                               fault;
	logic                               recover;

	// Narrow: low field bits in, zero-extended out. Wide: zero-extended in, low bits out.
	if (SAMPLE_BITS <= dpem_pkg::PRESS_W) begin : g_narrow
		assign smp = pressure[SAMPLE_BITS-1:0];
		assign res.filtered = dpem_pkg::PRESS_W'(r_sat);
	end else begin : g_wide
		assign smp = SAMPLE_BITS'(pressure);
		assign res.filtered = r_sat[dpem_pkg::PRESS_W-1:0];
	end

	// Hold on a bad sample, load if unseeded or unfiltered, else mix in, rounding half up.
	always_comb begin
		x        = {smp, {dpem_pkg::FRAC_BITS{1'b0}}};
		alpha_c  = (cfg.filter_alpha > dpem_pkg::ONE_Q16) ? dpem_pkg::ONE_Q16 : cfg.filter_alpha;
		beta     = dpem_pkg::ONE_Q16 - alpha_c;
		prod_new = NEW_W'(alpha_c) * NEW_W'(smp);
		prod_old = PROD_W'(beta) * PROD_W'(avg_q);
		sum      = SUM_W'({prod_new, {dpem_pkg::FRAC_BITS{1'b0}}}) + SUM_W'(prod_old)
			+ SUM_W'(dpem_pkg::HALF_Q16);
		if (!pressure_ok) begin
			avg_next = avg_q;
		end else if (!cfg.filter_enable || !seeded_q) begin
			avg_next = x;
		end else begin
			avg_next = sum[dpem_pkg::FRAC_BITS +: AVG_W];
		end
	end

	// Round the average to a whole sample and clamp it to the sample range.
	always_comb begin
		rnd    = {1'b0, avg_next} + (AVG_W + 1)'(dpem_pkg::HALF_Q16);
		r_full = rnd[AVG_W:dpem_pkg::FRAC_BITS];
		r_sat  = (r_full > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : r_full[SAMPLE_BITS-1:0];
	end

	// Voltage window check and the saturating error counter.
	always_comb begin
		fail     = !voltage_ok || (voltage < cfg.min_voltage_mv)
			|| (voltage > cfg.max_voltage_mv);
		cnt_up   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		cnt_dn   = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
		cnt_next = fail ? cnt_up : cnt_dn;
		fault    = fail && health_q && (CMP_W'(cnt_up) >= CMP_W'(cfg.error_limit));
		recover  = !fail && !health_q && (cnt_dn == '0);
	end

	assign res.fault_event   = fault;
	assign res.recover_event = recover;
	assign res.healthy       = fault ? 1'b0 : (recover ? 1'b1 : health_q);

	// Channel state moves on when the item is handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q    <= '0;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
			health_q <= 1'b1;
		end else if (upd) begin
			avg_q    <= avg_next;
			seeded_q <= seeded_q | pressure_ok;
			cnt_q    <= cnt_next;
			health_q <= res.healthy;
		end
	end

endmodule

[rtl/core/dual_pressure_ema_health_monitor_top.sv]
// Top level of the dual pressure averager and health monitor.
// Each input item is one sensor tick for two channels and gives exactly one result item.
// An item is captured in an input register; once the result register is free or being
// emptied, both channels update their average and error counter and write the result
// register, which offers the result. One item is taken every cycle while results are
// taken.
// The throughput is set by the single update stage: the average multiply and add and the
// counter step both fit in it. The output register and input register let a new item enter
// while a finished result still waits. Configuration writes must happen while idle.
module dual_pressure_ema_health_monitor_top #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpem_pkg::CFG_DATA_W-1:0]   cfg_data,
	dpem_in_if.sink                           sensor,
	dpem_out_if.source                        result
);

	dpem_pkg::cfg_t      cfg_q;
	dpem_pkg::in_item_t  item_s1;
	logic                valid_s1;
	dpem_pkg::out_item_t res_q;
	logic                res_valid_q;
	logic                adv;
	dpem_pkg::chan_res_t avl_res;
	dpem_pkg::chan_res_t tank_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_alpha   <= dpem_pkg::ALPHA_RST;
			cfg_q.filter_enable  <= dpem_pkg::ENABLE_RST;
			cfg_q.min_voltage_mv <= dpem_pkg::MIN_V_RST;
			cfg_q.max_voltage_mv <= dpem_pkg::MAX_V_RST;
			cfg_q.error_limit    <= dpem_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (dpem_pkg::cfg_idx_t'(cfg_index))
				dpem_pkg::CFG_FILTER_ALPHA: begin
					cfg_q.filter_alpha <= cfg_data;
				end
				dpem_pkg::CFG_FILTER_ENABLE: begin
					cfg_q.filter_enable <= cfg_data[0];
				end
				dpem_pkg::CFG_MIN_VOLTAGE_MV: begin
					cfg_q.min_voltage_mv <= cfg_data[dpem_pkg::VOLT_W-1:0];
				end
				dpem_pkg::CFG_MAX_VOLTAGE_MV: begin
					cfg_q.max_voltage_mv <= cfg_data[dpem_pkg::VOLT_W-1:0];
				end
				dpem_pkg::CFG_ERROR_LIMIT: begin
					cfg_q.error_limit <= cfg_data[dpem_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The update stage fires when the result register is free or being emptied.
	assign adv          = valid_s1 && (!res_valid_q || result.ready);
	assign sensor.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			item_s1 <= sensor.data;
		end
	end

	dpem_chan #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_avl (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (adv),
		.cfg         (cfg_q),
		.pressure    (item_s1.avl_pressure),
		.pressure_ok (item_s1.avl_pressure_ok),
		.voltage     (item_s1.avl_voltage),
		.voltage_ok  (item_s1.avl_voltage_ok),
		.res         (avl_res)
	);

	dpem_chan #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_tank (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (adv),
		.cfg         (cfg_q),
		.pressure    (item_s1.tank_pressure),
		.pressure_ok (item_s1.tank_pressure_ok),
		.voltage     (item_s1.tank_voltage),
		.voltage_ok  (item_s1.tank_voltage_ok),
		.res         (tank_res)
	);

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.avl_filtered       <= avl_res.filtered;
			res_q.tank_filtered      <= tank_res.filtered;
			res_q.readings_valid     <= item_s1.avl_pressure_ok & item_s1.tank_pressure_ok;
			res_q.avl_healthy        <= avl_res.healthy;
			res_q.tank_healthy       <= tank_res.healthy;
			res_q.avl_fault_event    <= avl_res.fault_event;
			res_q.avl_recover_event  <= avl_res.recover_event;
			res_q.tank_fault_event   <= tank_res.fault_event;
			res_q.tank_recover_event <= tank_res.recover_event;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

[rtl/core/dpem_checker.sv]
// Port-level checks of the monitor, attached to the top level by bind.
`include "assert_macros.svh"

module dpem_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input dpem_pkg::out_item_t out_data
);

	// A stalled result keeps its value.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// The input side only stalls behind a waiting result.
	`ASSERT_IMPL(a_ready_stall, !in_ready, out_valid, "input stalled with no result waiting")

	// Event pulses agree with the health flag they report.
	`ASSERT_IMPL(a_avl_events, out_valid, (!out_data.avl_fault_event || !out_data.avl_healthy) && (!out_data.avl_recover_event || out_data.avl_healthy), "first channel event disagrees with health")

	`ASSERT_IMPL(a_tank_events, out_valid, (!out_data.tank_fault_event || !out_data.tank_healthy) && (!out_data.tank_recover_event || out_data.tank_healthy), "second channel event disagrees with health")

endmodule

bind dual_pressure_ema_health_monitor_top dpem_checker u_dpem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sensor.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

[tb/tb.sv]
// Self-checking testbench of the dual pressure averager and health monitor top level.
import dpem_pkg::*;

// Predicts the result of every accepted sensor tick and checks the results that come back.
class ema_health_scoreboard;
	// Width of the error counter in the block under test.
	localparam int          COUNT_BITS  = 8;
	localparam int unsigned ERR_CNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int unsigned SAMPLE_MAX  = (1 << PRESS_W) - 1;

	typedef struct {
		longint unsigned avg;
		bit              seeded;
		int unsigned     err_cnt;
		bit              healthy;
	} chan_state_t;

	cfg_t        cfg;
	chan_state_t avl_st;
	chan_state_t tank_st;
	out_item_t   pending_results[$];
	int unsigned mismatches;
	int unsigned results_seen;

	function new();
		cfg.filter_alpha   = ALPHA_RST;
		cfg.filter_enable  = ENABLE_RST;
		cfg.min_voltage_mv = MIN_V_RST;
		cfg.max_voltage_mv = MAX_V_RST;
		cfg.error_limit    = LIMIT_RST;
		avl_st.avg         = 0;
		avl_st.seeded      = 0;
		avl_st.err_cnt     = 0;
		avl_st.healthy     = 1;
		tank_st            = avl_st;
		mismatches         = 0;
		results_seen       = 0;
	endfunction

	// Mirrors one register write.
	function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_FILTER_ALPHA:   cfg.filter_alpha = val[ALPHA_W-1:0];
			CFG_FILTER_ENABLE:  cfg.filter_enable = val[0];
			CFG_MIN_VOLTAGE_MV: cfg.min_voltage_mv = val[VOLT_W-1:0];
			CFG_MAX_VOLTAGE_MV: cfg.max_voltage_mv = val[VOLT_W-1:0];
			CFG_ERROR_LIMIT:    cfg.error_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
	endfunction

	// Moving average of one channel; the output is the rounded, saturated average.
	function void avg_step(inout chan_state_t c, input logic [PRESS_W-1:0] p,
			input logic ok, output logic [PRESS_W-1:0] filt);
		longint unsigned x;
		longint unsigned a;
		longint unsigned r;
		if (ok) begin
			x = 64'(p) << FRAC_BITS;
			if (!cfg.filter_enable || !c.seeded) begin
				c.avg = x;
			end else begin
				a = (cfg.filter_alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(cfg.filter_alpha);
				c.avg = (a * x + (64'(ONE_Q16) - a) * c.avg + 64'(HALF_Q16)) >> FRAC_BITS;
			end
			c.seeded = 1;
		end
		r = (c.avg + 64'(HALF_Q16)) >> FRAC_BITS;
		if (r > SAMPLE_MAX)
			r = SAMPLE_MAX;
		filt = r[PRESS_W-1:0];
	endfunction

	// Voltage window check, saturating error counter and health flag of one channel.
	function void health_step(inout chan_state_t c, input logic [VOLT_W-1:0] v,
			input logic ok, output logic fault, output logic recover);
		bit bad;
		bad = !ok || v < cfg.min_voltage_mv || v > cfg.max_voltage_mv;
		fault = 0;
		recover = 0;
		if (bad) begin
			if (c.err_cnt < ERR_CNT_MAX)
				c.err_cnt++;
			if (c.err_cnt >= cfg.error_limit && c.healthy) begin
				c.healthy = 0;
				fault = 1;
			end
		end else begin
			if (c.err_cnt > 0)
				c.err_cnt--;
			if (!c.healthy && c.err_cnt == 0) begin
				c.healthy = 1;
				recover = 1;
			end
		end
	endfunction

	// Works out the result of one accepted tick and queues it.
	function void note_tick(in_item_t t);
		out_item_t e;
		avg_step(avl_st, t.avl_pressure, t.avl_pressure_ok, e.avl_filtered);
		avg_step(tank_st, t.tank_pressure, t.tank_pressure_ok, e.tank_filtered);
		e.readings_valid = t.avl_pressure_ok & t.tank_pressure_ok;
		health_step(avl_st, t.avl_voltage, t.avl_voltage_ok,
			e.avl_fault_event, e.avl_recover_event);
		health_step(tank_st, t.tank_voltage, t.tank_voltage_ok,
			e.tank_fault_event, e.tank_recover_event);
		e.avl_healthy = avl_st.healthy;
		e.tank_healthy = tank_st.healthy;
		pending_results.push_back(e);
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task compare_field(string name, logic [PRESS_W-1:0] got, logic [PRESS_W-1:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
				results_seen, name, got, exp));
	endtask

	// Compares an accepted result with the oldest prediction.
	task check_result(out_item_t got);
		out_item_t e;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no tick pending", results_seen));
		end else begin
			e = pending_results.pop_front();
			compare_field("avl_filtered", got.avl_filtered, e.avl_filtered);
			compare_field("tank_filtered", got.tank_filtered, e.tank_filtered);
			compare_field("readings_valid", got.readings_valid, e.readings_valid);
			compare_field("avl_healthy", got.avl_healthy, e.avl_healthy);
			compare_field("tank_healthy", got.tank_healthy, e.tank_healthy);
			compare_field("avl_fault_event", got.avl_fault_event, e.avl_fault_event);
			compare_field("avl_recover_event", got.avl_recover_event, e.avl_recover_event);
			compare_field("tank_fault_event", got.tank_fault_event, e.tank_fault_event);
			compare_field("tank_recover_event", got.tank_recover_event, e.tank_recover_event);
		end
		results_seen++;
	endtask
endclass

module tb;
	localparam int          VOLT_TOP      = (1 << VOLT_W) - 1;
	localparam int unsigned TIMEOUT_UNITS = 2000000;

	// Receiver behavior, picked at random.
	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_RARELY,
		RX_PERIODIC
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dpem_in_if  sensor();
	dpem_out_if result();

	ema_health_scoreboard sb = new();

	rx_mode_t    rx_mode = RX_ALWAYS;
	int unsigned rx_mode_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned burst_left = 0;
	bit          avl_fault_run = 0;
	bit          tank_fault_run = 0;

	dual_pressure_ema_health_monitor_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensor    (sensor),
		.result    (result)
	);

	always #2 clk = ~clk;

	// Result side stalls on its own pattern.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
			rx_mode_left = $urandom_range(16, 96);
		end else begin
			rx_mode_left--;
		end
		rx_cycle++;
		case (rx_mode)
			RX_ALWAYS:   result.ready = 1'b1;
			RX_MOSTLY:   result.ready = ($urandom_range(0, 9) < 7);
			RX_RARELY:   result.ready = ($urandom_range(0, 9) < 3);
			RX_PERIODIC: result.ready = ((rx_cycle % 8) >= 3);
			default:     result.ready = 1'b1;
		endcase
	end

	// Every accepted result is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.data);
	end

	// Ends a run that hangs.
	initial begin
		#(TIMEOUT_UNITS);
		$display("dual_pressure_ema_health_monitor_top regression: fail");
		$finish;
	end

	function automatic in_item_t make_tick(
			logic [PRESS_W-1:0] ap, logic apok, logic [VOLT_W-1:0] av, logic avok,
			logic [PRESS_W-1:0] tp, logic tpok, logic [VOLT_W-1:0] tv, logic tvok);
		in_item_t t;
		t.avl_pressure = ap;
		t.avl_pressure_ok = apok;
		t.avl_voltage = av;
		t.avl_voltage_ok = avok;
		t.tank_pressure = tp;
		t.tank_pressure_ok = tpok;
		t.tank_voltage = tv;
		t.tank_voltage_ok = tvok;
		return t;
	endfunction

	// A pressure sample: mostly valid, with the extremes now and then.
	function automatic void pick_pressure(output logic [PRESS_W-1:0] p, output logic ok);
		int unsigned sel;
		sel = $urandom_range(0, 15);
		ok = (sel != 0);
		case (sel)
			1:       p = '0;
			2:       p = '1;
			default: p = $urandom_range(0, (1 << PRESS_W) - 1);
		endcase
	endfunction

	// A voltage that passes or fails the current window as asked.
	function automatic void pick_voltage(input bit want_fail,
			output logic [VOLT_W-1:0] v, output logic ok);
		int lo;
		int hi;
		int unsigned sel;
		lo = sb.cfg.min_voltage_mv;
		hi = sb.cfg.max_voltage_mv;
		ok = 1'b1;
		if (!want_fail) begin
			if (lo <= hi)
				v = $urandom_range(lo, hi);
			else
				v = $urandom_range(0, VOLT_TOP);
		end else begin
			sel = $urandom_range(0, 2);
			if (sel == 0 || (lo == 0 && hi == VOLT_TOP)) begin
				// Failed read, the voltage itself does not matter.
				ok = 1'b0;
				v = $urandom_range(0, VOLT_TOP);
			end else if ((sel == 1 && lo > 0) || hi == VOLT_TOP) begin
				v = $urandom_range(0, lo - 1);
			end else begin
				v = $urandom_range(hi + 1, VOLT_TOP);
			end
		end
	endfunction

	// Random tick: each channel goes through runs of mostly good or mostly bad voltage,
	// so that the health flag trips and recovers; a few ticks are plain noise.
	function automatic in_item_t make_random_tick();
		in_item_t t;
		if ($urandom_range(0, 31) == 0)
			avl_fault_run = !avl_fault_run;
		if ($urandom_range(0, 31) == 0)
			tank_fault_run = !tank_fault_run;
		if ($urandom_range(0, 15) == 0) begin
			t = make_tick($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else begin
			pick_pressure(t.avl_pressure, t.avl_pressure_ok);
			pick_pressure(t.tank_pressure, t.tank_pressure_ok);
			pick_voltage(avl_fault_run ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0),
				t.avl_voltage, t.avl_voltage_ok);
			pick_voltage(tank_fault_run ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0),
				t.tank_voltage, t.tank_voltage_ok);
		end
		return t;
	endfunction

	// Offers one tick and waits until it is accepted.
	task send_tick(in_item_t t);
		@(negedge clk);
		sensor.valid = 1'b1;
		sensor.data = t;
		@(posedge clk);
		while (!sensor.ready)
			@(posedge clk);
		sb.note_tick(t);
	endtask

	// Sender gap with junk on the data lines.
	task idle_sender(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			sensor.valid = 1'b0;
			sensor.data = make_tick($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end
	endtask

	// Stops sending and waits until every pending result has come back.
	task wait_idle();
		@(negedge clk);
		sensor.valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	task apply_settings(logic [ALPHA_W-1:0] alpha, logic enable, logic [VOLT_W-1:0] vmin,
			logic [VOLT_W-1:0] vmax, logic [LIMIT_W-1:0] limit);
		write_reg(CFG_FILTER_ALPHA, alpha);
		write_reg(CFG_FILTER_ENABLE, enable);
		write_reg(CFG_MIN_VOLTAGE_MV, vmin);
		write_reg(CFG_MAX_VOLTAGE_MV, vmax);
		write_reg(CFG_ERROR_LIMIT, limit);
	endtask

	// Random ticks in bursts of random length with random gaps between them.
	task run_random(int unsigned ticks);
		repeat (ticks) begin
			if (burst_left == 0) begin
				idle_sender($urandom_range(0, 6));
				burst_left = $urandom_range(1, 40);
			end
			send_tick(make_random_tick());
			burst_left--;
		end
	endtask

	// Directed ticks with the reset settings: no sample yet, seeding, extremes,
	// held average, window edges, a failed voltage read, a trip and a recovery.
	task run_directed();
		send_tick(make_tick(16'h1234, 1'b0, 13'd0, 1'b1, 16'h4321, 1'b0, 13'd8191, 1'b1));
		send_tick(make_tick(16'hFFFF, 1'b1, 13'd5000, 1'b1, 16'h0000, 1'b1, 13'd100, 1'b1));
		send_tick(make_tick(16'h0000, 1'b1, 13'd4999, 1'b0, 16'hFFFF, 1'b1, 13'd99, 1'b1));
		send_tick(make_tick(16'h8000, 1'b0, 13'd5001, 1'b1, 16'h7FFF, 1'b1, 13'd4096, 1'b1));
		// Repeated failures reach the limit and go past it.
		repeat (6)
			send_tick(make_tick(16'h5555, 1'b1, 13'd2730, 1'b0, 16'hAAAA, 1'b1, 13'd5461, 1'b0));
		// Passes bring the counters back to zero.
		repeat (8)
			send_tick(make_tick(16'hAAAA, 1'b1, 13'd2730, 1'b1, 16'h5555, 1'b1, 13'd1365, 1'b1));
	endtask

	initial begin
		int vmin;
		cfg_we = 1'b0;
		cfg_index = CFG_FILTER_ALPHA;
		cfg_data = '0;
		sensor.valid = 1'b0;
		sensor.data = '0;
		result.ready = 1'b0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		// Alpha zero holds the average; a zero limit trips on any failure.
		wait_idle();
		apply_settings('0, 1'b1, '0, 13'(VOLT_TOP), '0);
		run_random(100);

		// Full alpha, inverted window and the highest limit drive the counter to saturation.
		wait_idle();
		apply_settings(ONE_Q16, 1'b1, 13'd5000, 13'd100, 8'd255);
		run_random(280);

		// Alpha beyond unity, a window that holds zero alone, limit one.
		wait_idle();
		apply_settings('1, 1'b1, '0, '0, 8'd1);
		run_random(100);

		// Smallest nonzero alpha with filtering off.
		wait_idle();
		apply_settings(17'd1, 1'b0, 13'd2500, 13'd2600, 8'd3);
		run_random(140);

		// Random settings.
		repeat (4) begin
			wait_idle();
			vmin = $urandom_range(0, 5000);
			apply_settings($urandom_range(0, ONE_Q16 + 16), $urandom_range(0, 1), vmin,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(vmin, 5000),
				$urandom_range(1, 12));
			run_random(100);
		end

		// Near unity alpha with the reset window and limit.
		wait_idle();
		apply_settings(17'd65535, 1'b1, MIN_V_RST, MAX_V_RST, LIMIT_RST);
		run_random(60);

		wait_idle();
		repeat (8)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("dual_pressure_ema_health_monitor_top regression: pass");
		else
			$display("dual_pressure_ema_health_monitor_top regression: fail");
		$finish;
	end
endmodule
